FILE: hdl/rsbt_pkg.sv
`default_nettype none

package rsbt_pkg;

	localparam int MAX_RESOURCES    = 64;
	localparam int MAX_SUBRESOURCES = 16;
	localparam int STATE_BITS       = 4;

	localparam int HANDLE_W    = $clog2(MAX_RESOURCES);
	localparam int ECNT_W      = $clog2(MAX_RESOURCES + 1);
	localparam int IDX_W       = $clog2(MAX_SUBRESOURCES);
	localparam int SUB_W       = $clog2(MAX_SUBRESOURCES + 1);
	localparam int ADDR_W      = HANDLE_W + IDX_W;
	localparam int ENTRY_DEPTH = MAX_RESOURCES;
	localparam int STATE_DEPTH = MAX_RESOURCES * MAX_SUBRESOURCES;

	localparam logic [ECNT_W-1:0] ENTRY_FULL = ECNT_W'(MAX_RESOURCES);
	localparam logic [SUB_W-1:0]  ALL_SUBS   = SUB_W'(MAX_SUBRESOURCES);

	typedef enum logic [1:0] {
		OP_REG_TEX = 2'd0,
		OP_REG_BUF = 2'd1,
		OP_SET     = 2'd2,
		OP_TRANS   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK     = 3'd0,
		ERR_FULL   = 3'd1,
		ERR_HANDLE = 3'd2,
		ERR_SUB    = 3'd3,
		ERR_ZERO   = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		EMK_PLAIN   = 3'd0,
		EMK_ASSIGN  = 3'd1,
		EMK_SINGLE  = 3'd2,
		EMK_UNIFORM = 3'd3,
		EMK_PASS    = 3'd4
	} emk_t;

	typedef struct packed {
		logic capture;
		logic load_reg;
		logic load_n;
		logic idx_clr;
		logic idx_inc;
		logic rd_sub;
		logic scan_step;
		logic st_wr;
		logic emit;
		emk_t kind;
		err_t err;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic cnt_zero;
		logic cnt_big;
		logic bad_handle;
		logic meta_tex;
		logic sub_all;
		logic sub_bad;
		logic single_same;
		logic scan_last;
		logic uniform;
		logic first_same;
		logic pass_diff;
		logic idx_end;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: hdl/rsbt_dp.sv
`default_nettype none

module rsbt_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  rsbt_pkg::cmd_t                   cmd,
	output rsbt_pkg::sts_t                   sts,
	input  wire  [1:0]                       op,
	input  wire  [rsbt_pkg::HANDLE_W-1:0]    resource_handle,
	input  wire  [rsbt_pkg::SUB_W-1:0]       subresource_index,
	input  wire  [rsbt_pkg::STATE_BITS-1:0]  new_state,
	input  wire  [rsbt_pkg::SUB_W-1:0]       subresource_count,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [rsbt_pkg::HANDLE_W-1:0]    assigned_handle,
	output logic                             barrier_valid,
	output logic [rsbt_pkg::HANDLE_W-1:0]    barrier_handle,
	output logic [rsbt_pkg::SUB_W-1:0]       barrier_subresource,
	output logic [rsbt_pkg::STATE_BITS-1:0]  state_before,
	output logic [rsbt_pkg::STATE_BITS-1:0]  state_after,
	output logic [2:0]                       error_code,
	output logic                             last
);
	import rsbt_pkg::*;

	op_t                   op_q;
	logic [HANDLE_W-1:0]   h_q;
	logic [SUB_W-1:0]      sub_q;
	logic [STATE_BITS-1:0] st_q;
	logic [SUB_W-1:0]      cnt_q;
	logic [SUB_W-1:0]      n_q;
	logic [SUB_W-1:0]      idx_q;
	logic [ECNT_W-1:0]     entry_count_q;
	logic [STATE_BITS-1:0] first_q;
	logic                  uniform_q;
	logic [IDX_W-1:0]      lastdiff_q;
	logic [STATE_BITS-1:0] cache_q [MAX_SUBRESOURCES];

	logic                  meta_tex_mem [ENTRY_DEPTH];
	logic [SUB_W-1:0]      meta_cnt_mem [ENTRY_DEPTH];
	logic                  meta_tex_q;
	logic [SUB_W-1:0]      meta_cnt_q;
	logic [STATE_BITS-1:0] state_mem [STATE_DEPTH];
	logic [STATE_BITS-1:0] st_rd_q;

	logic                  out_vld_q;
	logic [HANDLE_W-1:0]   ahandle_q;
	logic                  bvld_q;
	logic [HANDLE_W-1:0]   bh_q;
	logic [SUB_W-1:0]      bsub_q;
	logic [STATE_BITS-1:0] sb_q;
	logic [STATE_BITS-1:0] sa_q;
	logic [2:0]            err_q;
	logic                  last_q;

	logic [SUB_W-1:0]      reg_cnt;
	logic [SUB_W-1:0]      scan_j;
	logic [IDX_W-1:0]      scan_j_idx;
	logic [IDX_W-1:0]      rd_idx;
	logic [ADDR_W-1:0]     st_addr;
	logic [HANDLE_W-1:0]   meta_addr;
	logic [STATE_BITS-1:0] pass_old;
	logic                  out_free;

	logic [HANDLE_W-1:0]   e_ahandle;
	logic                  e_bvld;
	logic [HANDLE_W-1:0]   e_bh;
	logic [SUB_W-1:0]      e_bsub;
	logic [STATE_BITS-1:0] e_sb;
	logic [STATE_BITS-1:0] e_sa;
	logic                  e_last;

	assign reg_cnt    = (op_q == OP_REG_TEX) ? cnt_q : SUB_W'(1);
	assign scan_j     = idx_q - SUB_W'(1);
	assign scan_j_idx = scan_j[IDX_W-1:0];
	assign rd_idx     = cmd.rd_sub ? (meta_tex_q ? sub_q[IDX_W-1:0] : '0) : idx_q[IDX_W-1:0];
	assign st_addr    = {h_q, rd_idx};
	assign meta_addr  = cmd.capture ? resource_handle : h_q;
	assign pass_old   = cache_q[idx_q[IDX_W-1:0]];
	assign out_free   = !out_vld_q || !out_stall;

	// item and scan registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(op);
			h_q   <= resource_handle;
			sub_q <= subresource_index;
			st_q  <= new_state;
			cnt_q <= subresource_count;
		end else if (cmd.load_reg) begin
			h_q <= entry_count_q[HANDLE_W-1:0];
		end
		if (cmd.load_reg) begin
			n_q <= reg_cnt;
		end else if (cmd.load_n) begin
			n_q <= meta_cnt_q;
		end
		if (cmd.capture || cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + SUB_W'(1);
		end
		if (cmd.scan_step) begin
			cache_q[scan_j_idx] <= st_rd_q;
			if (scan_j == '0) begin
				first_q   <= st_rd_q;
				uniform_q <= 1'b1;
			end else begin
				uniform_q <= uniform_q && (st_rd_q == first_q);
			end
			if (st_rd_q != st_q) begin
				lastdiff_q <= scan_j_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cmd.load_reg) begin
			entry_count_q <= entry_count_q + ECNT_W'(1);
		end
	end

	// entry table
	always_ff @(posedge clk) begin
		if (cmd.load_reg) begin
			meta_tex_mem[entry_count_q[HANDLE_W-1:0]] <= (op_q == OP_REG_TEX);
			meta_cnt_mem[entry_count_q[HANDLE_W-1:0]] <= reg_cnt;
		end
		meta_tex_q <= meta_tex_mem[meta_addr];
		meta_cnt_q <= meta_cnt_mem[meta_addr];
	end

	// subresource state table
	always_ff @(posedge clk) begin
		if (cmd.st_wr) begin
			state_mem[st_addr] <= st_q;
		end
		st_rd_q <= state_mem[st_addr];
	end

	always_comb begin
		sts.op          = op_q;
		sts.full        = (entry_count_q == ENTRY_FULL);
		sts.cnt_zero    = (cnt_q == '0);
		sts.cnt_big     = (cnt_q > ALL_SUBS);
		sts.bad_handle  = (ECNT_W'(h_q) >= entry_count_q);
		sts.meta_tex    = meta_tex_q;
		sts.sub_all     = (sub_q == ALL_SUBS);
		sts.sub_bad     = (sub_q >= meta_cnt_q);
		sts.single_same = (st_rd_q == st_q);
		sts.scan_last   = (scan_j == n_q - SUB_W'(1));
		sts.uniform     = uniform_q;
		sts.first_same  = (first_q == st_q);
		sts.pass_diff   = (pass_old != st_q);
		sts.idx_end     = (idx_q == n_q - SUB_W'(1));
		sts.out_free    = out_free;
	end

	always_comb begin
		e_ahandle = '0;
		e_bvld    = 1'b0;
		e_bh      = '0;
		e_bsub    = '0;
		e_sb      = '0;
		e_sa      = '0;
		e_last    = 1'b1;
		case (cmd.kind)
			EMK_PLAIN: begin
			end
			EMK_ASSIGN: begin
				e_ahandle = entry_count_q[HANDLE_W-1:0];
			end
			EMK_SINGLE: begin
				e_bvld = 1'b1;
				e_bh   = h_q;
				e_bsub = meta_tex_q ? sub_q : ALL_SUBS;
				e_sb   = st_rd_q;
				e_sa   = st_q;
			end
			EMK_UNIFORM: begin
				e_bvld = 1'b1;
				e_bh   = h_q;
				e_bsub = ALL_SUBS;
				e_sb   = first_q;
				e_sa   = st_q;
			end
			EMK_PASS: begin
				e_bvld = 1'b1;
				e_bh   = h_q;
				e_bsub = idx_q;
				e_sb   = pass_old;
				e_sa   = st_q;
				e_last = (idx_q[IDX_W-1:0] == lastdiff_q);
			end
			default: begin
			end
		endcase
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.emit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ahandle_q <= e_ahandle;
			bvld_q    <= e_bvld;
			bh_q      <= e_bh;
			bsub_q    <= e_bsub;
			sb_q      <= e_sb;
			sa_q      <= e_sa;
			err_q     <= cmd.err;
			last_q    <= e_last;
		end
	end

	assign out_valid           = out_vld_q;
	assign assigned_handle     = ahandle_q;
	assign barrier_valid       = bvld_q;
	assign barrier_handle      = bh_q;
	assign barrier_subresource = bsub_q;
	assign state_before        = sb_q;
	assign state_after         = sa_q;
	assign error_code          = err_q;
	assign last                = last_q;

endmodule

`default_nettype wire

FILE: hdl/rsbt_ctrl.sv
`default_nettype none

module rsbt_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  rsbt_pkg::sts_t sts,
	output rsbt_pkg::cmd_t cmd
);
	import rsbt_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CHECK  = 7'b0000010,
		S_SINGLE = 7'b0000100,
		S_SCAN   = 7'b0001000,
		S_DECIDE = 7'b0010000,
		S_FILL   = 7'b0100000,
		S_PASS   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_CHECK: begin
				case (sts.op)
					OP_REG_TEX, OP_REG_BUF: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = EMK_PLAIN;
							state_d  = S_IDLE;
							if (sts.full) begin
								cmd.err = ERR_FULL;
							end else if (sts.op == OP_REG_TEX && sts.cnt_zero) begin
								cmd.err = ERR_ZERO;
							end else if (sts.op == OP_REG_TEX && sts.cnt_big) begin
								cmd.err = ERR_SUB;
							end else begin
								cmd.kind     = EMK_ASSIGN;
								cmd.load_reg = 1'b1;
								cmd.idx_clr  = 1'b1;
								state_d      = S_FILL;
							end
						end
					end
					OP_SET: begin
						if (sts.out_free) begin
							cmd.emit = 1'b1;
							cmd.kind = EMK_PLAIN;
							if (sts.bad_handle) begin
								cmd.err = ERR_HANDLE;
								state_d = S_IDLE;
							end else begin
								cmd.load_n  = 1'b1;
								cmd.idx_clr = 1'b1;
								state_d     = S_FILL;
							end
						end
					end
					OP_TRANS: begin
						if (sts.bad_handle) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.err  = ERR_HANDLE;
								state_d  = S_IDLE;
							end
						end else if (!sts.meta_tex) begin
							if (sts.sub_all) begin
								cmd.rd_sub = 1'b1;
								state_d    = S_SINGLE;
							end else if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.err  = ERR_SUB;
								state_d  = S_IDLE;
							end
						end else if (sts.sub_all) begin
							cmd.load_n  = 1'b1;
							cmd.idx_inc = 1'b1;
							state_d     = S_SCAN;
						end else if (sts.sub_bad) begin
							if (sts.out_free) begin
								cmd.emit = 1'b1;
								cmd.err  = ERR_SUB;
								state_d  = S_IDLE;
							end
						end else begin
							cmd.rd_sub = 1'b1;
							state_d    = S_SINGLE;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SINGLE: begin
				cmd.rd_sub = 1'b1;
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
					if (!sts.single_same) begin
						cmd.kind  = EMK_SINGLE;
						cmd.st_wr = 1'b1;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.idx_inc   = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!sts.uniform) begin
					cmd.idx_clr = 1'b1;
					state_d     = S_PASS;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.first_same) begin
						state_d = S_IDLE;
					end else begin
						cmd.kind    = EMK_UNIFORM;
						cmd.idx_clr = 1'b1;
						state_d     = S_FILL;
					end
				end
			end
			S_FILL: begin
				cmd.st_wr   = 1'b1;
				cmd.idx_inc = 1'b1;
				if (sts.idx_end) begin
					state_d = S_IDLE;
				end
			end
			S_PASS: begin
				if (!sts.pass_diff || sts.out_free) begin
					cmd.idx_inc = 1'b1;
					if (sts.pass_diff) begin
						cmd.emit  = 1'b1;
						cmd.kind  = EMK_PASS;
						cmd.st_wr = 1'b1;
					end
					if (sts.idx_end) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/resource_state_barrier_tracker_core.sv
// Resource state tracker: registers textures and buffers in a 64-entry table, handing out
// handles in order, and turns transition requests into barrier words (handle,
// subresource, old state, new state), each input word giving one or more result words
// with last set on the final one. Input words are taken one at a time, only while the
// controller is idle; a result may wait in the output register while the next input is
// taken. With n the entry's subresource count, registration and set-state write n
// subresource states in turn; an all-subresource transition scans the n states and
// then rewrites those that differ from the new state. The single-port state table is
// scanned and rewritten one subresource per cycle, though the rewrite pass waits while
// an output stall holds a barrier word. The table needs no clearing pass after reset.
`default_nettype none

module resource_state_barrier_tracker_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_stall,
	input  wire  [1:0]                       op,
	input  wire  [rsbt_pkg::HANDLE_W-1:0]    resource_handle,
	input  wire  [rsbt_pkg::SUB_W-1:0]       subresource_index,
	input  wire  [rsbt_pkg::STATE_BITS-1:0]  new_state,
	input  wire  [rsbt_pkg::SUB_W-1:0]       subresource_count,
	output logic                             out_valid,
	input  wire                              out_stall,
	output logic [rsbt_pkg::HANDLE_W-1:0]    assigned_handle,
	output logic                             barrier_valid,
	output logic [rsbt_pkg::HANDLE_W-1:0]    barrier_handle,
	output logic [rsbt_pkg::SUB_W-1:0]       barrier_subresource,
	output logic [rsbt_pkg::STATE_BITS-1:0]  state_before,
	output logic [rsbt_pkg::STATE_BITS-1:0]  state_after,
	output logic [2:0]                       error_code,
	output logic                             last
);
	import rsbt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rsbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rsbt_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.sts                 (sts),
		.op                  (op),
		.resource_handle     (resource_handle),
		.subresource_index   (subresource_index),
		.new_state           (new_state),
		.subresource_count   (subresource_count),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.assigned_handle     (assigned_handle),
		.barrier_valid       (barrier_valid),
		.barrier_handle      (barrier_handle),
		.barrier_subresource (barrier_subresource),
		.state_before        (state_before),
		.state_after         (state_after),
		.error_code          (error_code),
		.last                (last)
	);

	a_bar_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && barrier_valid |-> error_code == ERR_OK)
		else $error("barrier word carries an error");

	a_nobar_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !barrier_valid |-> barrier_handle == '0 && barrier_subresource == '0
			&& state_before == '0 && state_after == '0)
		else $error("non-barrier word has barrier fields set");

	a_bar_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && barrier_valid |-> state_before != state_after)
		else $error("barrier with no state change");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_OK |-> last && assigned_handle == '0)
		else $error("error word not final or carries a handle");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted word did not make the block busy");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
	import rsbt_pkg::*;

	localparam int RANDOM_REQUESTS = 480;
	localparam int CYCLE_LIMIT     = 600000;
	localparam int DRAIN_CYCLES    = 80;
	localparam int HOLD_OFF_AT     = 150;
	localparam int HOLD_OFF_CYCLES = 400;

	typedef struct {
		op_t                   op;
		logic [HANDLE_W-1:0]   handle;
		logic [SUB_W-1:0]      sub;
		logic [STATE_BITS-1:0] state;
		logic [SUB_W-1:0]      count;
		int                    gap;
	} request_t;

	typedef struct packed {
		logic [HANDLE_W-1:0]   handle_out;
		logic                  barrier;
		logic [HANDLE_W-1:0]   barrier_for;
		logic [SUB_W-1:0]      sub_out;
		logic [STATE_BITS-1:0] from_state;
		logic [STATE_BITS-1:0] to_state;
		err_t                  err;
		logic                  final_word;
	} barrier_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [1:0]            op = '0;
	logic [HANDLE_W-1:0]   resource_handle = '0;
	logic [SUB_W-1:0]      subresource_index = '0;
	logic [STATE_BITS-1:0] new_state = '0;
	logic [SUB_W-1:0]      subresource_count = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [HANDLE_W-1:0]   assigned_handle;
	logic                  barrier_valid;
	logic [HANDLE_W-1:0]   barrier_handle;
	logic [SUB_W-1:0]      barrier_subresource;
	logic [STATE_BITS-1:0] state_before;
	logic [STATE_BITS-1:0] state_after;
	logic [2:0]            error_code;
	logic                  last;

	resource_state_barrier_tracker_core u_dut (.*);

	// predicted table contents
	int                    table_used = 0;
	bit                    is_texture [MAX_RESOURCES];
	int                    sub_total [MAX_RESOURCES];
	logic [STATE_BITS-1:0] sub_states [MAX_RESOURCES][MAX_SUBRESOURCES];

	// what the stimulus builder knows of the table
	int plan_used = 0;
	bit plan_tex [MAX_RESOURCES];
	int plan_subs [MAX_RESOURCES];
	bit sender_calm = 1'b0;

	request_t      pending [$];
	request_t      cur_req;
	barrier_word_t expected_words [$];
	barrier_word_t want;
	int            idle_left = 0;
	int            requests_taken = 0;
	int            hold_left = 0;
	int            hold_off_left = 0;
	bit            hold_off_done = 1'b0;
	bit            receiver_calm = 1'b0;
	int            stall_draw;
	int            mismatches = 0;
	int            cycle_count = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic barrier_word_t make_barrier(int h, int sub, logic [STATE_BITS-1:0] from,
			logic [STATE_BITS-1:0] to);
		barrier_word_t w;
		w = '0;
		w.barrier = 1'b1;
		w.barrier_for = HANDLE_W'(h);
		w.sub_out = SUB_W'(sub);
		w.from_state = from;
		w.to_state = to;
		return w;
	endfunction

	function automatic void predict_barriers(request_t rq);
		barrier_word_t         words [MAX_SUBRESOURCES];
		int                    k;
		int                    n;
		int                    i;
		int                    h;
		logic [STATE_BITS-1:0] old;
		logic [STATE_BITS-1:0] first;
		bit                    uniform;
		k = 1;
		h = int'(rq.handle);
		for (i = 0; i < MAX_SUBRESOURCES; i++)
			words[i] = '0;
		if (rq.op == OP_REG_TEX || rq.op == OP_REG_BUF) begin
			if (table_used >= MAX_RESOURCES) begin
				words[0].err = ERR_FULL;
			end else if (rq.op == OP_REG_TEX && rq.count == 0) begin
				words[0].err = ERR_ZERO;
			end else if (rq.op == OP_REG_TEX && rq.count > MAX_SUBRESOURCES) begin
				words[0].err = ERR_SUB;
			end else begin
				n = (rq.op == OP_REG_TEX) ? int'(rq.count) : 1;
				is_texture[table_used] = (rq.op == OP_REG_TEX);
				sub_total[table_used] = n;
				for (i = 0; i < n; i++)
					sub_states[table_used][i] = rq.state;
				words[0].handle_out = HANDLE_W'(table_used);
				table_used++;
			end
		end else if (h >= table_used) begin
			words[0].err = ERR_HANDLE;
		end else begin
			n = sub_total[h];
			if (rq.op == OP_SET) begin
				for (i = 0; i < n; i++)
					sub_states[h][i] = rq.state;
			end else if (!is_texture[h]) begin
				old = sub_states[h][0];
				if (rq.sub != ALL_SUBS) begin
					words[0].err = ERR_SUB;
				end else if (old != rq.state) begin
					words[0] = make_barrier(h, MAX_SUBRESOURCES, old, rq.state);
					sub_states[h][0] = rq.state;
				end
			end else if (rq.sub != ALL_SUBS) begin
				if (rq.sub >= n) begin
					words[0].err = ERR_SUB;
				end else begin
					old = sub_states[h][rq.sub[IDX_W-1:0]];
					if (old != rq.state) begin
						words[0] = make_barrier(h, int'(rq.sub), old, rq.state);
						sub_states[h][rq.sub[IDX_W-1:0]] = rq.state;
					end
				end
			end else begin
				first = sub_states[h][0];
				uniform = 1'b1;
				for (i = 1; i < n; i++)
					if (sub_states[h][i] != first)
						uniform = 1'b0;
				if (uniform) begin
					if (first != rq.state) begin
						words[0] = make_barrier(h, MAX_SUBRESOURCES, first, rq.state);
						for (i = 0; i < n; i++)
							sub_states[h][i] = rq.state;
					end
				end else begin
					k = 0;
					for (i = 0; i < n; i++) begin
						if (sub_states[h][i] != rq.state) begin
							words[k] = make_barrier(h, i, sub_states[h][i], rq.state);
							sub_states[h][i] = rq.state;
							k++;
						end
					end
					if (k == 0)
						k = 1;
				end
			end
		end
		words[k-1].final_word = 1'b1;
		for (i = 0; i < k; i++)
			expected_words = {expected_words, words[i]};
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
		if (got_val !== exp_val) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
			mismatches++;
		end
	endfunction

	function automatic int state_code();
		return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 15);
	endfunction

	task automatic add_request(op_t rq_op, int h, int sub, int st, int cnt);
		request_t rq;
		rq.op = rq_op;
		rq.handle = HANDLE_W'(h);
		rq.sub = SUB_W'(sub);
		rq.state = STATE_BITS'(st);
		rq.count = SUB_W'(cnt);
		rq.gap = sender_calm ? 0 : $urandom_range(0, 6);
		if (plan_used < MAX_RESOURCES && (rq_op == OP_REG_BUF
				|| (rq_op == OP_REG_TEX && cnt >= 1 && cnt <= MAX_SUBRESOURCES))) begin
			plan_tex[plan_used] = (rq_op == OP_REG_TEX);
			plan_subs[plan_used] = (rq_op == OP_REG_TEX) ? cnt : 1;
			plan_used++;
		end
		pending = {pending, rq};
	endtask

	task automatic offer_next();
		cur_req = pending.pop_front();
		op <= cur_req.op;
		resource_handle <= cur_req.handle;
		subresource_index <= cur_req.sub;
		new_state <= cur_req.state;
		subresource_count <= cur_req.count;
		in_valid <= 1'b1;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			idle_left <= 0;
		end else if (in_valid && !in_stall) begin
			predict_barriers(cur_req);
			requests_taken <= requests_taken + 1;
			if (cur_req.gap == 0 && pending.size() != 0) begin
				offer_next();
			end else begin
				in_valid <= 1'b0;
				idle_left <= (cur_req.gap == 0) ? 0 : cur_req.gap - 1;
			end
		end else if (!in_valid) begin
			if (idle_left != 0)
				idle_left <= idle_left - 1;
			else if (pending.size() != 0)
				offer_next();
		end
	end

	// long output hold-off so the block backs up into its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off_left <= 0;
			hold_off_done <= 1'b0;
		end else if (hold_off_left != 0) begin
			hold_off_left <= hold_off_left - 1;
		end else if (!hold_off_done && requests_taken >= HOLD_OFF_AT) begin
			hold_off_left <= HOLD_OFF_CYCLES;
			hold_off_done <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
		end else if (out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: expected no word, got handle %0d barrier %0b sub %0d error %0d",
					$time, barrier_handle, barrier_valid, barrier_subresource, error_code);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				check_field("assigned_handle", 8'(want.handle_out), 8'(assigned_handle));
				check_field("barrier_valid", 8'(want.barrier), 8'(barrier_valid));
				check_field("barrier_handle", 8'(want.barrier_for), 8'(barrier_handle));
				check_field("barrier_subresource", 8'(want.sub_out),
					8'(barrier_subresource));
				check_field("state_before", 8'(want.from_state), 8'(state_before));
				check_field("state_after", 8'(want.to_state), 8'(state_after));
				check_field("error_code", 8'(want.err), 8'(error_code));
				check_field("last", 8'(want.final_word), 8'(last));
			end
			if ($urandom_range(0, 29) == 0)
				receiver_calm = !receiver_calm;
			stall_draw = receiver_calm ? 0 : $urandom_range(0, 6);
			hold_left <= stall_draw;
			out_stall <= (stall_draw != 0) || (hold_off_left != 0);
		end else begin
			if (hold_left != 0)
				hold_left <= hold_left - 1;
			out_stall <= (hold_left > 1) || (hold_off_left != 0);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		int all_code;
		int pick;
		int h;
		int n_rand;
		all_code = int'(ALL_SUBS);

		// directed words
		add_request(OP_REG_TEX, 63, 31, 0, 16);
		add_request(OP_REG_BUF, 0, 0, 15, 0);
		add_request(OP_REG_TEX, 0, 0, 7, 1);
		add_request(OP_REG_TEX, 0, 0, 3, 0);
		add_request(OP_REG_TEX, 0, 0, 3, 17);
		add_request(OP_REG_TEX, 0, 0, 3, 31);
		add_request(OP_SET, 63, 0, 5, 0);
		add_request(OP_TRANS, 3, all_code, 5, 0);
		add_request(OP_TRANS, 0, all_code, 0, 0);
		add_request(OP_TRANS, 0, all_code, 9, 0);
		add_request(OP_TRANS, 0, 3, 9, 0);
		add_request(OP_TRANS, 0, 3, 2, 0);
		add_request(OP_TRANS, 0, all_code, 2, 0);
		add_request(OP_TRANS, 0, 31, 4, 0);
		add_request(OP_TRANS, 2, 1, 4, 0);
		add_request(OP_TRANS, 1, 0, 4, 0);
		add_request(OP_TRANS, 1, all_code, 15, 0);
		add_request(OP_TRANS, 1, all_code, 0, 0);
		add_request(OP_SET, 1, 0, 10, 0);
		add_request(OP_SET, 0, 0, 1, 0);
		add_request(OP_TRANS, 0, 15, 2, 0);
		add_request(OP_TRANS, 0, all_code, 3, 0);
		add_request(OP_TRANS, 2, 0, 15, 0);
		add_request(OP_TRANS, 2, all_code, 15, 0);

		// random words, mostly valid requests on registered entries
		for (n_rand = 0; n_rand < RANDOM_REQUESTS; n_rand++) begin
			if ($urandom_range(0, 39) == 0)
				sender_calm = !sender_calm;
			pick = $urandom_range(0, 99);
			h = (plan_used == 0) ? 0 : $urandom_range(0, plan_used - 1);
			if (plan_used == 0 || pick < ((plan_used < MAX_RESOURCES) ? 18 : 3)) begin
				if ($urandom_range(0, 9) < 7)
					add_request(OP_REG_TEX, $urandom_range(0, 63), $urandom_range(0, 31),
						state_code(), $urandom_range(1, 16));
				else
					add_request(OP_REG_BUF, $urandom_range(0, 63), $urandom_range(0, 31),
						state_code(), $urandom_range(0, 31));
			end else if (pick < 33) begin
				add_request(OP_SET, h, $urandom_range(0, 31), state_code(),
					$urandom_range(0, 31));
			end else if (pick < 63) begin
				add_request(OP_TRANS, h,
					plan_tex[h] ? $urandom_range(0, plan_subs[h] - 1) : all_code,
					state_code(), $urandom_range(0, 31));
			end else if (pick < 88) begin
				add_request(OP_TRANS, h, all_code, state_code(), $urandom_range(0, 31));
			end else begin
				case ($urandom_range(0, 3))
					0: add_request($urandom_range(0, 1) ? OP_SET : OP_TRANS,
						(plan_used < MAX_RESOURCES) ? $urandom_range(plan_used, 63) : h,
						$urandom_range(0, 31), state_code(), $urandom_range(0, 31));
					1: add_request(OP_TRANS, h, $urandom_range(17, 31), state_code(),
						$urandom_range(0, 31));
					2: add_request(OP_TRANS, h,
						!plan_tex[h] ? $urandom_range(0, 15)
						: (plan_subs[h] < MAX_SUBRESOURCES)
						? $urandom_range(plan_subs[h], 15) : 0,
						state_code(), $urandom_range(0, 31));
					default: add_request(OP_REG_TEX, $urandom_range(0, 63),
						$urandom_range(0, 31), state_code(),
						$urandom_range(0, 1) ? 0 : $urandom_range(17, 31));
				endcase
			end
		end

		// fill the table, then overflow it
		while (plan_used < MAX_RESOURCES)
			add_request(OP_REG_BUF, 0, 0, state_code(), 0);
		add_request(OP_REG_TEX, 0, 0, 0, 4);
		add_request(OP_REG_BUF, 0, 0, 0, 0);
		add_request(OP_TRANS, 63, all_code, 15, 0);
		add_request(OP_TRANS, 63, all_code, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (pending.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && expected_words.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
